@@ rtl/core/grc_pkg.sv @@
// Shared types, widths and constants of the grid ray casting unit.
package grc_pkg;

	localparam int CW = 56;
	localparam int TW = 31;
	localparam int PW = 53;
	localparam int ZW = 25;
	localparam int LW = 22;
	localparam int SW = 44;
	localparam int DW = 20;
	localparam int AGW = 15;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST = 1'b1;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [7:0] CODE_EMPTY = 8'd0;
	localparam logic [7:0] CODE_OPEN_O = 8'd79;
	localparam logic [7:0] CODE_OPEN_K = 8'd75;

	localparam logic signed [CW-1:0] ONE = 56'sd1048576;
	localparam logic signed [CW-1:0] NUDGE = 56'sd104858;
	localparam logic signed [CW-1:0] FAR = 56'sd1048576000;
	localparam logic signed [PW-1:0] FAR_P = 53'sd1048576000;
	localparam logic signed [LW-1:0] ONE_L = 22'sd1048576;
	localparam logic signed [TW-1:0] CORDIC_START = 31'sd268435456;

	localparam logic signed [16:0] ANG_TURN = 17'sd23040;
	localparam logic [AGW-1:0] QUARTER = 15'd5760;
	localparam logic [AGW-1:0] HALF = 15'd11520;
	localparam logic [AGW-1:0] THREE_QUARTER = 15'd17280;

	localparam logic [LW-1:0] LEG_MAX = 22'd2097152;
	localparam logic [DW-1:0] DIST_MAX = 20'd1048575;
	localparam logic signed [7:0] HIT_LOW = -8'sd1;
	localparam logic signed [7:0] HIT_HIGH = 8'sd64;

	typedef struct packed {
		logic kind;
		logic [5:0] cell_col;
		logic [5:0] cell_row;
		logic [7:0] cell_code;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic signed [15:0] ray_angle;
	} cmd_t;

	typedef struct packed {
		logic [19:0] hit_distance;
		logic horizontal_hit;
		logic signed [7:0] hit_col;
		logic signed [7:0] hit_row;
		logic [9:0] wall_offset;
	} res_t;

	function automatic logic [21:0] atan_step(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117305;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/core/grc_div.sv @@
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module grc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [grc_pkg::PW-1:0] num,
	input logic signed [grc_pkg::TW-1:0] den,
	output logic done,
	output logic signed [grc_pkg::PW-1:0] quo
);

	localparam int PW = grc_pkg::PW;
	localparam int TW = grc_pkg::TW;
	localparam int CNTW = $clog2(PW + 1);

	logic [PW-1:0] nm_q;
	logic [TW-1:0] dm_q;
	logic [TW-1:0] rem_q;
	logic [CNTW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic neg_q;
	logic nneg_q;
	logic zero_q;
	logic [TW:0] trial_w;
	logic take_w;

	assign trial_w = {rem_q, nm_q[PW-1]};
	assign take_w = trial_w >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= CNTW'(PW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nm_q <= num[PW-1] ? PW'(-num) : PW'(num);
			dm_q <= den[TW-1] ? TW'(-den) : TW'(den);
			rem_q <= '0;
			neg_q <= num[PW-1] ^ den[TW-1];
			nneg_q <= num[PW-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			nm_q <= {nm_q[PW-2:0], take_w};
			rem_q <= take_w ? TW'(trial_w - {1'b0, dm_q}) : trial_w[TW-1:0];
		end
	end

	assign done = done_q;
	assign quo = zero_q ? (nneg_q ? -grc_pkg::FAR_P : grc_pkg::FAR_P)
		: (neg_q ? -$signed(nm_q) : $signed(nm_q));

endmodule

@@ rtl/core/grc_isqrt.sv @@
// Iterative floor square root, one result bit per cycle, with saturated output.
module grc_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [grc_pkg::SW-1:0] rad,
	output logic done,
	output logic [grc_pkg::DW-1:0] root
);

	localparam int SW = grc_pkg::SW;
	localparam int DW = grc_pkg::DW;

	logic [SW-1:0] n_q;
	logic [SW-1:0] root_q;
	logic [SW-1:0] bit_q;
	logic busy_q;
	logic done_q;
	logic [SW:0] sum_w;
	logic take_w;

	assign sum_w = {1'b0, root_q} + {1'b0, bit_q};
	assign take_w = {1'b0, n_q} >= sum_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= rad;
			root_q <= '0;
			bit_q <= {2'b01, {(SW-2){1'b0}}};
		end else if (busy_q) begin
			if (take_w) begin
				n_q <= n_q - sum_w[SW-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = (root_q > SW'(grc_pkg::DIST_MAX)) ? grc_pkg::DIST_MAX : root_q[DW-1:0];

endmodule

@@ rtl/core/grid_ray_cast_unit.sv @@
// Top level of the grid ray casting unit: map memory, sequencer and datapath.
//
// Items enter on the cmd channel (valid/ready). A write item stores one cell
// code in the map memory in the cycle it is accepted and gives no result. A
// cast item reduces the angle, runs a 20-step CORDIC, four serial divisions
// for the crossing offsets and steps, then walks the row crossings and the
// column crossings, reading one map cell in each probe state and testing it in
// a check state, and finally takes two iterative square roots.
// One item is worked on at a time; cmd_ready is high only while the sequencer
// is idle. The result waits in an output register on the res channel; a new
// item may be accepted while it waits, and a finished ray holds until that
// register is free, so a stalled receiver never loses a result.
// Reset clears the sequencer, the output valid flag and sets the map size
// registers to 64; the map memory is not cleared and every cell must be
// written before a ray reads it. The APB port sets map_width and map_height.
module grid_ray_cast_unit #(
	parameter int MAP_COLS = 64,
	parameter int MAP_ROWS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input grc_pkg::cmd_t cmd,
	output logic res_valid,
	input logic res_ready,
	output grc_pkg::res_t res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int CW = grc_pkg::CW;
	localparam int TW = grc_pkg::TW;
	localparam int PW = grc_pkg::PW;
	localparam int ZW = grc_pkg::ZW;
	localparam int LW = grc_pkg::LW;
	localparam int SW = grc_pkg::SW;
	localparam int DW = grc_pkg::DW;
	localparam int AGW = grc_pkg::AGW;
	localparam int DEPTH = MAP_COLS * MAP_ROWS;
	localparam int AW = $clog2(DEPTH);
	localparam int RIW = $clog2(MAP_ROWS);
	localparam int CIW = $clog2(MAP_COLS);
	localparam int IW = CW - 20;
	localparam logic signed [IW-1:0] IDX_ONE = 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED = 4'd1;
	localparam logic [3:0] S_QUAD = 4'd2;
	localparam logic [3:0] S_ROT = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_DIVGO = 4'd5;
	localparam logic [3:0] S_DIVW = 4'd6;
	localparam logic [3:0] S_WSTART = 4'd7;
	localparam logic [3:0] S_PROBE = 4'd8;
	localparam logic [3:0] S_CHECK = 4'd9;
	localparam logic [3:0] S_LEG = 4'd10;
	localparam logic [3:0] S_SQ0 = 4'd11;
	localparam logic [3:0] S_SQ1 = 4'd12;
	localparam logic [3:0] S_SUM = 4'd13;
	localparam logic [3:0] S_SQW = 4'd14;
	localparam logic [3:0] S_OUT = 4'd15;

	function automatic logic signed [TW-1:0] shr_tz(input logic signed [TW-1:0] v,
		input logic [4:0] s);
		logic [TW-1:0] m;
		m = v[TW-1] ? TW'(-v) : TW'(v);
		m = m >> s;
		return v[TW-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [LW-1:0] leg_q10(input logic signed [CW-1:0] v);
		logic [CW-1:0] m;
		m = v[CW-1] ? CW'(-v) : CW'(v);
		if (m[CW-1:10] > {{(CW-10-LW){1'b0}}, grc_pkg::LEG_MAX}) begin
			return grc_pkg::LEG_MAX;
		end
		return m[LW+9:10];
	endfunction

	function automatic logic signed [7:0] cell_coord(input logic signed [CW-1:0] v);
		if (v[CW-1]) begin
			return (v <= -grc_pkg::ONE) ? grc_pkg::HIT_LOW : 8'sd0;
		end
		if (v[CW-1:20] > IW'(64)) begin
			return grc_pkg::HIT_HIGH;
		end
		return $signed(v[27:20]);
	endfunction

	logic [3:0] state_q;
	logic [6:0] width_q;
	logic [6:0] height_q;
	logic [7:0] map_mem_q [DEPTH];
	logic [7:0] rd_data_q;

	logic [15:0] px_q;
	logic [15:0] py_q;
	logic signed [16:0] ang_q;
	logic [1:0] q_q;
	logic [12:0] r_q;
	logic signed [TW-1:0] x_q;
	logic signed [TW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic [4:0] it_q;
	logic [1:0] job_q;
	logic signed [PW-1:0] prod_q;
	logic signed [CW-1:0] ax_q;
	logic signed [CW-1:0] ay_q;
	logic signed [CW-1:0] sxa_q;
	logic signed [CW-1:0] bx_q;
	logic signed [CW-1:0] by_q;
	logic signed [CW-1:0] syb_q;
	logic sya_neg_q;
	logic sxb_neg_q;
	logic dir_q;
	logic dsel_q;
	logic [LW-1:0] la_q;
	logic [LW-1:0] lb_q;
	logic [SW-1:0] sqa_q;
	logic [SW-1:0] sqb_q;
	logic [DW-1:0] d1_q;
	logic [DW-1:0] d2_q;
	logic res_valid_q;
	grc_pkg::res_t res_q;

	logic [AGW-1:0] angle_w;
	logic [1:0] q_w;
	logic [12:0] r_w;
	logic row_skip_w;
	logic col_skip_w;
	logic signed [TW-1:0] c_w;
	logic signed [TW-1:0] s_w;
	logic signed [LW-1:0] mul_a_w;
	logic signed [TW-1:0] mul_b_w;
	logic div_done_w;
	logic signed [PW-1:0] quo_w;
	logic signed [CW-1:0] quo_ext_w;
	logic sq_done_w;
	logic [DW-1:0] root_w;
	logic hor_w;
	logic pdir_w;
	logic signed [CW-1:0] org_x_w;
	logic signed [CW-1:0] org_y_w;
	logic signed [CW-1:0] prb_x_w;
	logic signed [CW-1:0] prb_y_w;
	logic signed [IW-1:0] ix_w;
	logic signed [IW-1:0] iy_w;
	logic signed [IW-1:0] wlim_w;
	logic signed [IW-1:0] hlim_w;
	logic inb_w;
	logic pass_w;
	logic walk_end_w;
	logic walk_adv_w;
	logic load_w;
	logic wr_en_w;
	logic [AW-1:0] waddr_w;
	logic [AW-1:0] raddr_w;
	logic cfg_wr_w;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr_w = psel && penable && pwrite;
	assign prdata = (paddr[2] == grc_pkg::REG_HEIGHT) ? {25'd0, height_q} : {25'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_wr_w) begin
			if (paddr[2] == grc_pkg::REG_WIDTH) begin
				width_q <= pwdata[6:0];
			end else begin
				height_q <= pwdata[6:0];
			end
		end
	end

	// Angle, quadrant and trigonometry.
	assign angle_w = ang_q[AGW-1:0];
	assign row_skip_w = (angle_w == '0) || (angle_w == grc_pkg::HALF);
	assign col_skip_w = (angle_w == grc_pkg::QUARTER) || (angle_w == grc_pkg::THREE_QUARTER);

	always_comb begin
		if (angle_w >= grc_pkg::THREE_QUARTER) begin
			q_w = 2'd3;
			r_w = 13'(angle_w - grc_pkg::THREE_QUARTER);
		end else if (angle_w >= grc_pkg::HALF) begin
			q_w = 2'd2;
			r_w = 13'(angle_w - grc_pkg::HALF);
		end else if (angle_w >= grc_pkg::QUARTER) begin
			q_w = 2'd1;
			r_w = 13'(angle_w - grc_pkg::QUARTER);
		end else begin
			q_w = 2'd0;
			r_w = 13'(angle_w);
		end
	end

	always_comb begin
		case (q_q)
			2'd0: begin
				c_w = x_q;
				s_w = y_q;
			end
			2'd1: begin
				c_w = -y_q;
				s_w = x_q;
			end
			2'd2: begin
				c_w = -x_q;
				s_w = -y_q;
			end
			default: begin
				c_w = y_q;
				s_w = -x_q;
			end
		endcase
	end

	always_comb begin
		case (job_q)
			2'd0: mul_a_w = ay_q[LW-1:0];
			2'd1: mul_a_w = sya_neg_q ? -grc_pkg::ONE_L : grc_pkg::ONE_L;
			2'd2: mul_a_w = bx_q[LW-1:0];
			default: mul_a_w = sxb_neg_q ? -grc_pkg::ONE_L : grc_pkg::ONE_L;
		endcase
	end
	assign mul_b_w = job_q[1] ? s_w : c_w;

	grc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == S_DIVGO),
		.num(prod_q),
		.den(job_q[1] ? c_w : s_w),
		.done(div_done_w),
		.quo(quo_w)
	);
	assign quo_ext_w = {{(CW-PW){quo_w[PW-1]}}, quo_w};

	grc_isqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == S_SUM),
		.rad(SW'(sqa_q + sqb_q)),
		.done(sq_done_w),
		.root(root_w)
	);

	// Probe point of the current walk, or of the nearer walk when reporting.
	assign hor_w = !(d1_q > d2_q);
	assign pdir_w = (state_q == S_OUT) ? !hor_w : dir_q;
	assign org_x_w = CW'({px_q, 10'd0});
	assign org_y_w = CW'({py_q, 10'd0});

	always_comb begin
		if (!pdir_w) begin
			prb_x_w = org_x_w + ax_q;
			prb_y_w = org_y_w + ay_q + (sya_neg_q ? -grc_pkg::NUDGE : grc_pkg::NUDGE);
		end else begin
			prb_x_w = org_x_w + bx_q + (sxb_neg_q ? -grc_pkg::NUDGE : grc_pkg::NUDGE);
			prb_y_w = org_y_w + by_q;
		end
	end

	assign ix_w = prb_x_w[CW-1:20];
	assign iy_w = prb_y_w[CW-1:20];
	assign wlim_w = IW'((9'(width_q) < 9'(MAP_COLS)) ? 9'(width_q) : 9'(MAP_COLS));
	assign hlim_w = IW'((9'(height_q) < 9'(MAP_ROWS)) ? 9'(height_q) : 9'(MAP_ROWS));
	assign inb_w = (ix_w >= IDX_ONE) && (iy_w >= IDX_ONE) && (ix_w < wlim_w) && (iy_w < hlim_w);
	assign raddr_w = AW'(AW'(iy_w[RIW-1:0]) * AW'(MAP_COLS)) + AW'(ix_w[CIW-1:0]);

	assign pass_w = (rd_data_q == grc_pkg::CODE_EMPTY) || (rd_data_q == grc_pkg::CODE_OPEN_O)
		|| (rd_data_q == grc_pkg::CODE_OPEN_K);
	assign walk_end_w = ((state_q == S_PROBE) && !inb_w) || ((state_q == S_CHECK) && !pass_w);
	assign walk_adv_w = (state_q == S_CHECK) && pass_w;

	// Map memory.
	assign cmd_ready = (state_q == S_IDLE);
	assign wr_en_w = cmd_valid && cmd_ready && (cmd.kind == grc_pkg::KIND_WRITE)
		&& (9'(cmd.cell_col) < 9'(MAP_COLS)) && (9'(cmd.cell_row) < 9'(MAP_ROWS));
	assign waddr_w = AW'(AW'(cmd.cell_row) * AW'(MAP_COLS)) + AW'(cmd.cell_col);

	always_ff @(posedge clk) begin
		if (wr_en_w) begin
			map_mem_q[waddr_w] <= cmd.cell_code;
		end
		if (state_q == S_PROBE) begin
			rd_data_q <= map_mem_q[raddr_w];
		end
	end

	// Sequencer.
	assign load_w = (state_q == S_OUT) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			it_q <= '0;
			job_q <= '0;
			dir_q <= 1'b0;
			dsel_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && (cmd.kind == grc_pkg::KIND_CAST)) begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (!ang_q[16] && (ang_q < grc_pkg::ANG_TURN)) begin
						state_q <= S_QUAD;
					end
				end
				S_QUAD: begin
					state_q <= S_ROT;
					it_q <= '0;
					job_q <= '0;
				end
				S_ROT: begin
					it_q <= it_q + 5'd1;
					if ((r_q == '0) || (it_q == 5'd19)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_DIVGO;
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done_w) begin
						job_q <= job_q + 2'd1;
						if (job_q == 2'd3) begin
							state_q <= S_WSTART;
							dir_q <= 1'b0;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_WSTART: begin
					if (!dir_q) begin
						if (row_skip_w) begin
							dir_q <= 1'b1;
						end else begin
							state_q <= S_PROBE;
						end
					end else if (col_skip_w) begin
						state_q <= S_LEG;
						dsel_q <= 1'b0;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE, S_CHECK: begin
					if (walk_end_w) begin
						if (!dir_q) begin
							dir_q <= 1'b1;
							state_q <= S_WSTART;
						end else begin
							state_q <= S_LEG;
							dsel_q <= 1'b0;
						end
					end else if (state_q == S_PROBE) begin
						state_q <= S_CHECK;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_LEG: state_q <= S_SQ0;
				S_SQ0: state_q <= S_SQ1;
				S_SQ1: state_q <= S_SUM;
				S_SUM: state_q <= S_SQW;
				S_SQW: begin
					if (sq_done_w) begin
						if (!dsel_q) begin
							dsel_q <= 1'b1;
							state_q <= S_LEG;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (load_w) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && cmd_valid && (cmd.kind == grc_pkg::KIND_CAST)) begin
			px_q <= cmd.origin_x;
			py_q <= cmd.origin_y;
			ang_q <= 17'(cmd.ray_angle);
		end
		if (state_q == S_RED) begin
			if (ang_q[16]) begin
				ang_q <= ang_q + grc_pkg::ANG_TURN;
			end else if (ang_q >= grc_pkg::ANG_TURN) begin
				ang_q <= ang_q - grc_pkg::ANG_TURN;
			end
		end
		if (state_q == S_QUAD) begin
			q_q <= q_w;
			r_q <= r_w;
			x_q <= grc_pkg::CORDIC_START;
			y_q <= '0;
			z_q <= ZW'({r_w, 10'd0});
			sya_neg_q <= angle_w > grc_pkg::HALF;
			sxb_neg_q <= (angle_w >= grc_pkg::QUARTER) && (angle_w <= grc_pkg::THREE_QUARTER);
			ay_q <= (angle_w <= grc_pkg::HALF) ? grc_pkg::ONE - CW'({py_q[9:0], 10'd0})
				: -CW'({py_q[9:0], 10'd0});
			bx_q <= ((angle_w >= grc_pkg::QUARTER) && (angle_w <= grc_pkg::THREE_QUARTER))
				? -CW'({px_q[9:0], 10'd0}) : grc_pkg::ONE - CW'({px_q[9:0], 10'd0});
		end
		if ((state_q == S_ROT) && (r_q != '0)) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - shr_tz(y_q, it_q);
				y_q <= y_q + shr_tz(x_q, it_q);
				z_q <= z_q - ZW'(grc_pkg::atan_step(it_q));
			end else begin
				x_q <= x_q + shr_tz(y_q, it_q);
				y_q <= y_q - shr_tz(x_q, it_q);
				z_q <= z_q + ZW'(grc_pkg::atan_step(it_q));
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= mul_a_w * mul_b_w;
		end
		if ((state_q == S_DIVW) && div_done_w) begin
			case (job_q)
				2'd0: ax_q <= row_skip_w ? grc_pkg::FAR : quo_ext_w;
				2'd1: sxa_q <= quo_ext_w;
				2'd2: by_q <= col_skip_w ? grc_pkg::FAR : quo_ext_w;
				default: syb_q <= quo_ext_w;
			endcase
		end
		if (walk_adv_w) begin
			if (!dir_q) begin
				ax_q <= ax_q + sxa_q;
				ay_q <= ay_q + (sya_neg_q ? -grc_pkg::ONE : grc_pkg::ONE);
			end else begin
				bx_q <= bx_q + (sxb_neg_q ? -grc_pkg::ONE : grc_pkg::ONE);
				by_q <= by_q + syb_q;
			end
		end
		if (state_q == S_LEG) begin
			la_q <= leg_q10(dsel_q ? bx_q : ax_q);
			lb_q <= leg_q10(dsel_q ? by_q : ay_q);
		end
		if (state_q == S_SQ0) begin
			sqa_q <= la_q * la_q;
		end
		if (state_q == S_SQ1) begin
			sqb_q <= lb_q * lb_q;
		end
		if ((state_q == S_SQW) && sq_done_w) begin
			if (!dsel_q) begin
				d1_q <= root_w;
			end else begin
				d2_q <= root_w;
			end
		end
		if (load_w) begin
			res_q.hit_distance <= hor_w ? d1_q : d2_q;
			res_q.horizontal_hit <= hor_w;
			res_q.hit_col <= cell_coord(prb_x_w);
			res_q.hit_row <= cell_coord(prb_y_w);
			res_q.wall_offset <= hor_w ? prb_x_w[19:10] : prb_y_w[19:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_w) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
